/* rtl/bsrd_pkg.sv */
`default_nettype none
package bsrd_pkg;

    localparam int DIGITS_DEF       = 128;
    localparam int CHUNK_DIGITS_DEF = 16;
    localparam int CHUNK_BITS       = 64;

    typedef enum logic [1:0] {
        ACT_DIGIT  = 2'd0,
        ACT_MINUS  = 2'd1,
        ACT_END    = 2'd2,
        ACT_FINISH = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] digit;
    } in_word_t;

    typedef struct packed {
        logic [CHUNK_BITS-1:0] digit_chunk;
        logic [2:0]            chunk_index;
        logic [7:0]            significant_digits;
        logic                  overflow;
        logic                  no_numbers;
        logic                  last;
    } out_word_t;

    // which sweep the read issued this cycle belongs to
    typedef enum logic [2:0] {
        PH_NONE,
        PH_CMP,
        PH_COPY,
        PH_SUB,
        PH_GATHER
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   first;        // first digit of a chunk
        logic   do_digit;
        logic   do_minus;
        logic   clr;          // clear compare flags and carry, restart significant-digit count
        logic   decide;
        logic   clear_cur;
        logic   set_have;
        logic   load_out;
        logic   last_chunk;
        logic   finish_done;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic upd_any;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* rtl/bcd_signed_range_difference_core.sv */
`default_nettype none
// channel  dir  ports                           word
// input    in   s_valid s_ready s_in           action, digit
// result   out  m_valid m_ready m_out          digit_chunk, chunk_index,
//                                               significant_digits, overflow,
//                                               no_numbers, last
// digit and minus words are taken while idle, with no sweep
// end of number: serial compare sweep, then copy sweep,
//   no copy sweep when neither bound changes, no sweep if empty
// finish: serial subtract sweep, then a gather sweep and a push per chunk, each push
//   waiting while m_ready stays low; the last chunk may wait while new input is taken
// reset is synchronous on aresetn; digit stores need no clearing pass
module bcd_signed_range_difference_core
    import bsrd_pkg::*;
#(
    parameter int DIGITS       = bsrd_pkg::DIGITS_DEF,
    parameter int CHUNK_DIGITS = bsrd_pkg::CHUNK_DIGITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bsrd_pkg::in_word_t  s_in,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bsrd_pkg::out_word_t      m_out
);

    localparam int NC = (DIGITS + CHUNK_DIGITS - 1) / CHUNK_DIGITS;
    localparam int PW = $clog2(NC * CHUNK_DIGITS);
    localparam int KW = (NC > 1) ? $clog2(NC) : 1;

    cmd_t          cmd;
    status_t       st;
    logic [PW-1:0] pos;
    logic [KW-1:0] chunk;

    bsrd_ctrl #(.DIGITS(DIGITS), .CHUNK_DIGITS(CHUNK_DIGITS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .action(s_in.action), .st(st), .cmd(cmd), .pos(pos), .chunk(chunk)
    );

    bsrd_dp #(.DIGITS(DIGITS), .CHUNK_DIGITS(CHUNK_DIGITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .pos(pos), .chunk(chunk),
        .digit_in(s_in.digit), .st(st), .m_valid(m_valid), .m_ready(m_ready),
        .m_out(m_out)
    );

endmodule
`default_nettype wire

/* rtl/bsrd_ram.sv */
`default_nettype none
module bsrd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/bsrd_ctrl.sv */
`default_nettype none
module bsrd_ctrl #(
    parameter int DIGITS = 128,
    parameter int CHUNK_DIGITS = 16,
    localparam int NC = (DIGITS + CHUNK_DIGITS - 1) / CHUNK_DIGITS,
    localparam int PW = $clog2(NC * CHUNK_DIGITS),
    localparam int KW = (NC > 1) ? $clog2(NC) : 1,
    localparam int CW = (CHUNK_DIGITS > 1) ? $clog2(CHUNK_DIGITS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        action,
    input  wire bsrd_pkg::status_t st,
    output bsrd_pkg::cmd_t         cmd,
    output logic      [PW-1:0]     pos,
    output logic      [KW-1:0]     chunk
);
    import bsrd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CMP, S_CDRAIN, S_DECIDE, S_COPY, S_KDRAIN,
        S_SUB, S_SDRAIN, S_GATH, S_GDRAIN, S_PUSH
    } state_t;

    state_t        state_reg;
    logic [PW-1:0] pos_reg;
    logic [CW-1:0] dcnt_reg;
    logic [KW-1:0] chunk_reg;

    logic last_k;
    assign last_k = (chunk_reg == KW'(NC - 1));

    assign s_ready = (state_reg == S_IDLE);
    assign pos     = pos_reg;
    assign chunk   = chunk_reg;

    always_comb begin
        cmd = '0;
        cmd.phase = PH_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (action)
                        ACT_DIGIT: cmd.do_digit = 1'b1;
                        ACT_MINUS: cmd.do_minus = 1'b1;
                        ACT_END: begin
                            if (st.len_zero) cmd.clear_cur = 1'b1;
                            else cmd.clr = 1'b1;
                        end
                        default: cmd.clr = 1'b1;
                    endcase
                end
            end
            S_CMP:    cmd.phase = PH_CMP;
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (!st.upd_any) cmd.clear_cur = 1'b1;
            end
            S_COPY:   cmd.phase = PH_COPY;
            S_KDRAIN: begin
                cmd.clear_cur = 1'b1;
                cmd.set_have  = 1'b1;
            end
            S_SUB:    cmd.phase = PH_SUB;
            S_GATH: begin
                cmd.phase = PH_GATHER;
                cmd.first = (dcnt_reg == '0);
            end
            S_PUSH: begin
                if (st.out_free) begin
                    cmd.load_out    = 1'b1;
                    cmd.last_chunk  = last_k;
                    cmd.finish_done = last_k;
                end
            end
            default: cmd.phase = PH_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            dcnt_reg  <= '0;
            chunk_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        case (action)
                            ACT_END: begin
                                if (!st.len_zero) begin
                                    pos_reg   <= PW'(DIGITS - 1);
                                    state_reg <= S_CMP;
                                end
                            end
                            ACT_FINISH: begin
                                pos_reg   <= '0;
                                state_reg <= S_SUB;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CMP: begin
                    pos_reg <= pos_reg - 1'b1;
                    if (pos_reg == '0) state_reg <= S_CDRAIN;
                end
                S_CDRAIN: state_reg <= S_DECIDE;
                S_DECIDE: begin
                    pos_reg   <= PW'(DIGITS - 1);
                    state_reg <= st.upd_any ? S_COPY : S_IDLE;
                end
                S_COPY: begin
                    pos_reg <= pos_reg - 1'b1;
                    if (pos_reg == '0) state_reg <= S_KDRAIN;
                end
                S_KDRAIN: state_reg <= S_IDLE;
                S_SUB: begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == PW'(DIGITS - 1)) state_reg <= S_SDRAIN;
                end
                S_SDRAIN: begin
                    pos_reg   <= PW'(NC * CHUNK_DIGITS - 1);
                    dcnt_reg  <= '0;
                    chunk_reg <= '0;
                    state_reg <= S_GATH;
                end
                S_GATH: begin
                    pos_reg <= pos_reg - 1'b1;
                    if (dcnt_reg == CW'(CHUNK_DIGITS - 1)) begin
                        dcnt_reg  <= '0;
                        state_reg <= S_GDRAIN;
                    end else begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                end
                S_GDRAIN: state_reg <= S_PUSH;
                S_PUSH: begin
                    if (st.out_free) begin
                        if (last_k) begin
                            state_reg <= S_IDLE;
                        end else begin
                            chunk_reg <= chunk_reg + 1'b1;
                            state_reg <= S_GATH;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/bsrd_dp.sv */
`default_nettype none
module bsrd_dp #(
    parameter int DIGITS = 128,
    parameter int CHUNK_DIGITS = 16,
    localparam int NC = (DIGITS + CHUNK_DIGITS - 1) / CHUNK_DIGITS,
    localparam int PW = $clog2(NC * CHUNK_DIGITS),
    localparam int KW = (NC > 1) ? $clog2(NC) : 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bsrd_pkg::cmd_t      cmd,
    input  wire logic [PW-1:0]       pos,
    input  wire logic [KW-1:0]       chunk,
    input  wire logic [3:0]          digit_in,
    output bsrd_pkg::status_t        st,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bsrd_pkg::out_word_t      m_out
);
    import bsrd_pkg::*;

    localparam int AW = $clog2(DIGITS);
    localparam int LW = $clog2(DIGITS + 1);

    typedef enum logic [1:0] {MAG_EQ, MAG_GT, MAG_LT} mag_t;

    logic [LW-1:0] len_reg;
    logic          neg_reg, have_reg, ovf_reg;
    logic          max_neg_reg, min_neg_reg;
    mag_t          cmx_reg, cmn_reg;
    logic          nz_reg, upd_max_reg, upd_min_reg, cy_reg;
    logic [LW-1:0] sig_reg;
    phase_t        s1_ph_reg;
    logic [AW-1:0] s1_pos_reg;
    logic          s1_curv_reg, s1_first_reg, s1_inr_reg;
    logic [CHUNK_BITS-1:0] acc_reg;
    logic          m_valid_reg;
    out_word_t     out_reg;

    logic [3:0] cur_rdata, max_rdata, min_rdata;
    logic [3:0] cur_d, dig_clamped, a, b, dsub, dadd, dres;
    logic [4:0] t5, s5;
    logic       borrow, carry, add_mode, cy_new;
    logic       cur_we, max_we, min_we;
    logic [3:0] max_wd;
    logic [AW-1:0] cur_waddr, cur_raddr;
    logic       curv, inr;
    logic       neg_c, gtmax, ltmin, upd_max_c, upd_min_c;

    assign dig_clamped = (digit_in > 4'd9) ? 4'd9 : digit_in;

    // current number is stored in arrival order, so position p sits at len-1-p
    assign cur_raddr = AW'(len_reg - LW'(1) - LW'(pos[AW-1:0]));
    assign curv      = (LW'(pos[AW-1:0]) < len_reg);
    assign inr       = ({1'b0, pos} < (PW+1)'(DIGITS));
    assign cur_we    = cmd.do_digit && (len_reg != LW'(DIGITS));
    assign cur_waddr = AW'(len_reg);
    assign cur_d     = s1_curv_reg ? cur_rdata : 4'd0;

    assign add_mode = (max_neg_reg != min_neg_reg);
    assign a  = min_neg_reg ? (max_neg_reg ? min_rdata : max_rdata) : max_rdata;
    assign b  = min_neg_reg ? (max_neg_reg ? max_rdata : min_rdata) : min_rdata;
    assign t5 = {1'b0, a} - {1'b0, b} - {4'b0, cy_reg};
    assign borrow = t5[4];
    assign dsub = borrow ? (t5[3:0] + 4'd10) : t5[3:0];
    assign s5 = {1'b0, max_rdata} + {1'b0, min_rdata} + {4'b0, cy_reg};
    assign carry = (s5 >= 5'd10);
    assign dadd = carry ? 4'(s5 - 5'd10) : s5[3:0];
    assign dres = have_reg ? (add_mode ? dadd : dsub) : 4'd0;
    assign cy_new = have_reg && (add_mode ? carry : borrow);

    assign max_we = (s1_ph_reg == PH_SUB) || ((s1_ph_reg == PH_COPY) && upd_max_reg);
    assign min_we = (s1_ph_reg == PH_COPY) && upd_min_reg;
    assign max_wd = (s1_ph_reg == PH_SUB) ? dres : cur_d;

    // minus zero counts as zero
    assign neg_c = neg_reg && nz_reg;
    assign gtmax = (neg_c != max_neg_reg) ? !neg_c
                 : (neg_c ? (cmx_reg == MAG_LT) : (cmx_reg == MAG_GT));
    assign ltmin = (neg_c != min_neg_reg) ? neg_c
                 : (neg_c ? (cmn_reg == MAG_GT) : (cmn_reg == MAG_LT));
    assign upd_max_c = !have_reg || gtmax;
    assign upd_min_c = !have_reg || ltmin;

    assign st.len_zero = (len_reg == '0);
    assign st.upd_any  = upd_max_c || upd_min_c;
    assign st.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_out   = out_reg;

    bsrd_ram #(.WIDTH(4), .DEPTH(DIGITS)) u_cur (
        .aclk(aclk), .wr_en(cur_we), .wr_addr(cur_waddr), .wr_data(dig_clamped),
        .rd_addr(cur_raddr), .rd_data(cur_rdata)
    );
    bsrd_ram #(.WIDTH(4), .DEPTH(DIGITS)) u_max (
        .aclk(aclk), .wr_en(max_we), .wr_addr(s1_pos_reg), .wr_data(max_wd),
        .rd_addr(pos[AW-1:0]), .rd_data(max_rdata)
    );
    bsrd_ram #(.WIDTH(4), .DEPTH(DIGITS)) u_min (
        .aclk(aclk), .wr_en(min_we), .wr_addr(s1_pos_reg), .wr_data(cur_d),
        .rd_addr(pos[AW-1:0]), .rd_data(min_rdata)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        s1_pos_reg   <= pos[AW-1:0];
        s1_curv_reg  <= curv;
        s1_first_reg <= cmd.first;
        s1_inr_reg   <= inr;
        if (cmd.clr) begin
            cmx_reg <= MAG_EQ;
            cmn_reg <= MAG_EQ;
            nz_reg  <= 1'b0;
            cy_reg  <= 1'b0;
            sig_reg <= LW'(1);
        end else begin
            if (s1_ph_reg == PH_CMP) begin
                if (cmx_reg == MAG_EQ && cur_d != max_rdata)
                    cmx_reg <= (cur_d > max_rdata) ? MAG_GT : MAG_LT;
                if (cmn_reg == MAG_EQ && cur_d != min_rdata)
                    cmn_reg <= (cur_d > min_rdata) ? MAG_GT : MAG_LT;
                if (cur_d != 4'd0) nz_reg <= 1'b1;
            end
            if (s1_ph_reg == PH_SUB) begin
                cy_reg <= cy_new;
                if (dres != 4'd0) sig_reg <= LW'(s1_pos_reg) + LW'(1);
            end
        end
        if (s1_ph_reg == PH_GATHER) begin
            if (s1_first_reg)
                acc_reg <= CHUNK_BITS'(s1_inr_reg ? max_rdata : 4'd0);
            else
                acc_reg <= {acc_reg[CHUNK_BITS-5:0], (s1_inr_reg ? max_rdata : 4'd0)};
        end
        if (cmd.decide) begin
            upd_max_reg <= upd_max_c;
            upd_min_reg <= upd_min_c;
            if (upd_max_c) max_neg_reg <= neg_c;
            if (upd_min_c) min_neg_reg <= neg_c;
        end
        if (cmd.load_out) begin
            out_reg.digit_chunk        <= acc_reg;
            out_reg.chunk_index        <= 3'(chunk);
            out_reg.significant_digits <= 8'(sig_reg);
            out_reg.overflow           <= ovf_reg || (have_reg && add_mode && cy_reg);
            out_reg.no_numbers         <= !have_reg;
            out_reg.last               <= cmd.last_chunk;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            neg_reg     <= 1'b0;
            have_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            s1_ph_reg   <= PH_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            s1_ph_reg <= cmd.phase;
            if (cmd.do_digit) begin
                if (cur_we) len_reg <= len_reg + 1'b1;
                else ovf_reg <= 1'b1;
            end
            if (cmd.do_minus) neg_reg <= 1'b1;
            if (cmd.clear_cur || cmd.finish_done) begin
                len_reg <= '0;
                neg_reg <= 1'b0;
            end
            if (cmd.set_have) have_reg <= 1'b1;
            if (cmd.finish_done) begin
                have_reg <= 1'b0;
                ovf_reg  <= 1'b0;
            end
            if (cmd.load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(DIGITS))
        else $error("digit count beyond capacity");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten before taken");

    a_have_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(have_reg) |-> $past(cmd.finish_done))
        else $error("number record lost outside finish");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
    import bsrd_pkg::*;

    localparam int NDIG   = DIGITS_DEF;
    localparam int CHD    = CHUNK_DIGITS_DEF;
    localparam int NCHUNK = (NDIG + CHD - 1) / CHD;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_in = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_out;

    bcd_signed_range_difference_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_in(s_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_out(m_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // range tracker state
    logic [3:0] cur_dig [NDIG];
    logic       cur_neg;
    int         cur_len;
    logic [3:0] hi_dig [NDIG];
    logic       hi_neg;
    logic [3:0] lo_dig [NDIG];
    logic       lo_neg;
    logic       seen_num;
    logic       ovf_seen;

    in_word_t  word_q [$];
    out_word_t chunk_q [$];
    int        fails = 0;
    bit        hold_tx = 1'b0;
    bit        tx_done = 1'b0;

    function automatic int mag_order(input logic [3:0] a [NDIG], input logic [3:0] b [NDIG]);
        for (int i = NDIG - 1; i >= 0; i--)
            if (a[i] != b[i]) return (a[i] > b[i]) ? 1 : -1;
        return 0;
    endfunction

    function automatic int sgn_order(input logic an, input logic [3:0] a [NDIG],
                                     input logic bn, input logic [3:0] b [NDIG]);
        if (an != bn) return an ? -1 : 1;
        return an ? -mag_order(a, b) : mag_order(a, b);
    endfunction

    task automatic clear_range();
        for (int i = 0; i < NDIG; i++) begin
            cur_dig[i] = 0;
            hi_dig[i] = 0;
            lo_dig[i] = 0;
        end
        cur_neg = 0; cur_len = 0; hi_neg = 0; lo_neg = 0;
        seen_num = 0; ovf_seen = 0;
    endtask

    task automatic track_word(input in_word_t w);
        logic [3:0] diff [NDIG];
        logic [3:0] d;
        logic       neg, nz, ovf;
        int         s, cy, sig;
        out_word_t  o;
        case (action_t'(w.action))
            ACT_DIGIT: begin
                d = (w.digit > 9) ? 4'd9 : w.digit;
                if (cur_len >= NDIG) ovf_seen = 1;
                else begin
                    for (int i = NDIG - 1; i > 0; i--) cur_dig[i] = cur_dig[i-1];
                    cur_dig[0] = d;
                    cur_len++;
                end
            end
            ACT_MINUS: cur_neg = 1;
            ACT_END: begin
                if (cur_len != 0) begin
                    nz = 0;
                    for (int i = 0; i < NDIG; i++) if (cur_dig[i] != 0) nz = 1;
                    neg = cur_neg && nz;
                    if (!seen_num) begin
                        hi_dig = cur_dig; lo_dig = cur_dig;
                        hi_neg = neg; lo_neg = neg; seen_num = 1;
                    end else begin
                        if (sgn_order(neg, cur_dig, hi_neg, hi_dig) > 0) begin
                            hi_dig = cur_dig; hi_neg = neg;
                        end
                        if (sgn_order(neg, cur_dig, lo_neg, lo_dig) < 0) begin
                            lo_dig = cur_dig; lo_neg = neg;
                        end
                    end
                end
                for (int i = 0; i < NDIG; i++) cur_dig[i] = 0;
                cur_neg = 0; cur_len = 0;
            end
            default: begin
                ovf = ovf_seen;
                cy = 0;
                for (int i = 0; i < NDIG; i++) begin
                    if (!seen_num) s = 0;
                    else if (hi_neg == lo_neg) begin
                        s = hi_neg ? lo_dig[i] - hi_dig[i] - cy : hi_dig[i] - lo_dig[i] - cy;
                        cy = s < 0;
                        if (s < 0) s += 10;
                    end else begin
                        s = hi_dig[i] + lo_dig[i] + cy;
                        cy = s >= 10;
                        if (cy) s -= 10;
                    end
                    diff[i] = s[3:0];
                end
                if (seen_num && hi_neg != lo_neg && cy) ovf = 1;
                sig = 1;
                for (int i = NDIG - 1; i > 0; i--)
                    if (diff[i] != 0) begin
                        sig = i + 1;
                        break;
                    end
                for (int k = 0; k < NCHUNK; k++) begin
                    o = '0;
                    for (int j = CHD - 1; j >= 0; j--) begin
                        s = (NCHUNK - 1 - k) * CHD + j;
                        o.digit_chunk = {o.digit_chunk[59:0], (s < NDIG) ? diff[s] : 4'd0};
                    end
                    o.chunk_index = k[2:0];
                    o.significant_digits = sig[7:0];
                    o.overflow = ovf;
                    o.no_numbers = !seen_num;
                    o.last = (k == NCHUNK - 1);
                    chunk_q.push_back(o);
                end
                clear_range();
            end
        endcase
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // driver
    int tx_gap = 0;
    bit gap_on = 1'b1;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) track_word(s_in);
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (word_q.size() > 0 && !hold_tx) begin
                s_in <= word_q.pop_front();
                s_valid <= 1'b1;
                if (gap_on) tx_gap = gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    int rx_gap = 0;
    out_word_t exp_w;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (chunk_q.size() == 0) begin
                    $display("%0t unexpected word %h", $time, m_out);
                    fails++;
                end else begin
                    exp_w = chunk_q.pop_front();
                    if (m_out !== exp_w) begin
                        $display("%0t mismatch expected %h actual %h", $time, exp_w, m_out);
                        fails++;
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (gap_on) rx_gap = gap_len();
            end
        end
    end

    task automatic push_num(input bit neg, input int len, input bit big);
        if (neg) word_q.push_back({ACT_MINUS, 4'($urandom)});
        for (int i = 0; i < len; i++)
            word_q.push_back({ACT_DIGIT, big ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9))});
        word_q.push_back({ACT_END, 4'($urandom)});
    endtask

    task automatic push_word(input action_t a, input logic [3:0] d);
        word_q.push_back({a, d});
    endtask

    initial begin
        int n, len;
        bit ng;
        clear_range();
        // directed
        push_word(ACT_FINISH, 4'hF);               // finish with no numbers
        push_word(ACT_DIGIT, 4'd0);
        push_word(ACT_MINUS, 4'd0);
        push_word(ACT_MINUS, 4'd0);                // minus zero, repeated sign
        push_word(ACT_END, 4'd0);
        push_word(ACT_END, 4'd5);                  // empty number
        push_word(ACT_DIGIT, 4'd15);               // clamps to nine
        push_word(ACT_DIGIT, 4'd10);
        push_word(ACT_END, 4'd0);
        push_word(ACT_MINUS, 4'd0);
        push_word(ACT_DIGIT, 4'd7);
        push_word(ACT_END, 4'd0);
        push_word(ACT_FINISH, 4'd0);
        push_num(1, 3, 0); push_num(1, 2, 0); push_word(ACT_FINISH, 4'd0);
        push_num(0, 2, 0); push_word(ACT_FINISH, 4'd0);
        // max-length and over-length operands, carry out of the sum
        for (int i = 0; i < NDIG + 2; i++) push_word(ACT_DIGIT, 4'd9);
        push_word(ACT_END, 4'd0);
        push_word(ACT_MINUS, 4'd0);
        for (int i = 0; i < NDIG; i++) push_word(ACT_DIGIT, 4'd9);
        push_word(ACT_END, 4'd0);
        push_word(ACT_FINISH, 4'd0);
        // random batches
        n = 0;
        while (n < 190) begin
            repeat ($urandom_range(1, 6)) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(NDIG - 2, NDIG + 1)
                                                   : $urandom_range(0, 20);
                ng = $urandom_range(0, 1);
                push_num(ng, len, $urandom_range(0, 7) == 0);
                n += len + 1 + int'(ng);
            end
            if ($urandom_range(0, 5) == 0) begin
                push_word(ACT_MINUS, 4'($urandom));
                n++;
            end
            push_word(ACT_FINISH, 4'($urandom));
            n++;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // let part of the queued words drain, then hold off
        wait (word_q.size() < 300);
        @(posedge aclk);
        hold_tx = 1'b1;
        wait (chunk_q.size() == 0 && !s_valid);
        repeat (300) @(posedge aclk);
        hold_tx = 1'b0;
        wait (word_q.size() < 150);
        gap_on = 1'b0;                   // stretch without idling
        wait (word_q.size() < 80);
        gap_on = 1'b1;
        wait (word_q.size() == 0 && !s_valid);
        wait (chunk_q.size() == 0);
        repeat (600) @(posedge aclk);
        if (fails == 0 && chunk_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/bsrd_pkg.sv
rtl/bsrd_ram.sv
rtl/bsrd_ctrl.sv
rtl/bsrd_dp.sv
rtl/bcd_signed_range_difference_core.sv
tb/testbench.sv
